>>> src/adaptive_symbol_frequency_model_defines.svh
// Assertion macros shared by the adaptive symbol frequency model
`ifndef ADAPTIVE_SYMBOL_FREQUENCY_MODEL_DEFINES_SVH
`define ADAPTIVE_SYMBOL_FREQUENCY_MODEL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASFM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASFM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> src/asfm_pkg.sv
// Shared types, constants and helpers of the adaptive symbol frequency model
package asfm_pkg;

    localparam int MAX_SYMBOLS_DEF = 256;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int RANGE_W  = 41;
    localparam int SYMBOL_W = 8;
    localparam int CFG_W    = 9;
    localparam int FOUND_W  = 9;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef struct packed {
        logic load;        // item accepted, capture fields
        logic clr_wr;      // write zero at index (clearing sweep)
        logic issue;       // read entry at index into the pipeline
        logic pass2;       // entries in flight belong to the weight pass
        logic set_factor;  // form escape factor from distinct count
        logic calc_total;  // form total and seed bounds
        logic update;      // count the encoded symbol
        logic finish;      // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic last_idx;    // index is the last symbol in use
        logic pipe_busy;   // read pipeline still holds entries
        logic out_free;    // output register can take a result
    } t_dp_sts;

    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

>>> src/asfm_ctrl.sv
// Sequencer for the clearing sweep and the two passes over the count memory
module asfm_ctrl #(
    parameter int MAX_SYMBOLS = asfm_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_valid,
    output logic                                        o_in_stall,
    input  asfm_pkg::t_dp_sts                           i_sts,
    output asfm_pkg::t_dp_cmd                           o_cmd,
    output logic [asfm_pkg::idx_width(MAX_SYMBOLS)-1:0] o_idx
);

    localparam int IDX_W = asfm_pkg::idx_width(MAX_SYMBOLS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SYMBOLS - 1);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_P1     = 4'd2;
    localparam logic [3:0] S_P1_DRN = 4'd3;
    localparam logic [3:0] S_FACTOR = 4'd4;
    localparam logic [3:0] S_TOTAL  = 4'd5;
    localparam logic [3:0] S_P2     = 4'd6;
    localparam logic [3:0] S_P2_DRN = 4'd7;
    localparam logic [3:0] S_UPDATE = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = S_P1;
                end
            end
            S_P1: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_idx) begin
                    n_idx   = '0;
                    n_state = S_P1_DRN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_P1_DRN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_FACTOR;
                end
            end
            S_FACTOR: begin
                o_cmd.set_factor = 1'b1;
                n_state          = S_TOTAL;
            end
            S_TOTAL: begin
                o_cmd.calc_total = 1'b1;
                n_state          = S_P2;
            end
            S_P2: begin
                o_cmd.issue = 1'b1;
                o_cmd.pass2 = 1'b1;
                if (i_sts.last_idx) begin
                    n_idx   = '0;
                    n_state = S_P2_DRN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_P2_DRN: begin
                o_cmd.pass2 = 1'b1;
                if (!i_sts.pipe_busy) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_idx   = '0;
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_idx      = r_idx;

endmodule

>>> src/asfm_dp.sv
// Count memory, weight pipeline, accumulators and output register
module asfm_dp #(
    parameter int MAX_SYMBOLS = asfm_pkg::MAX_SYMBOLS_DEF,
    parameter int COUNT_BITS  = asfm_pkg::COUNT_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  asfm_pkg::t_dp_cmd                           i_cmd,
    input  logic [asfm_pkg::idx_width(MAX_SYMBOLS)-1:0] i_idx,
    output asfm_pkg::t_dp_sts                           o_sts,
    input  logic                                        i_cfg_we,
    input  logic [asfm_pkg::CFG_W-1:0]                  i_cfg_wdata,
    input  logic                                        i_operation,
    input  logic [asfm_pkg::SYMBOL_W-1:0]               i_symbol,
    input  logic [asfm_pkg::RANGE_W-1:0]                i_cumulative_value,
    output logic                                        o_out_valid,
    input  logic                                        i_out_stall,
    output logic [asfm_pkg::RANGE_W-1:0]                o_range_low,
    output logic [asfm_pkg::RANGE_W-1:0]                o_range_high,
    output logic [asfm_pkg::RANGE_W-1:0]                o_range_total,
    output logic [asfm_pkg::FOUND_W-1:0]                o_found_symbol,
    output logic                                        o_overflow
);

    localparam int IDX_W = asfm_pkg::idx_width(MAX_SYMBOLS);
    localparam int M_W   = $clog2(MAX_SYMBOLS + 1);
    localparam int C_W   = (M_W > asfm_pkg::CFG_W) ? M_W : asfm_pkg::CFG_W;
    localparam int P_W   = COUNT_BITS + 1 + M_W;
    localparam int X_W   = (P_W > asfm_pkg::RANGE_W) ? P_W : asfm_pkg::RANGE_W;

    // configuration and alphabet size clamp
    logic [asfm_pkg::CFG_W-1:0] r_cfg;
    logic [C_W-1:0]             cfg_c, max_c, m_c, sym_c, i2_c, found_c;
    logic [M_W-1:0]             m;

    // captured item
    logic                                r_op;
    logic [asfm_pkg::SYMBOL_W-1:0]       r_sym;
    logic [asfm_pkg::RANGE_W-1:0]        r_val;
    logic                                in_range;
    logic [IDX_W-1:0]                    sym_idx;

    // count memory
    logic [COUNT_BITS-1:0] mem [MAX_SYMBOLS];
    logic [COUNT_BITS-1:0] r_rdata;
    logic                  wr_en, upd_wr, sat;
    logic [IDX_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    // weight pipeline
    logic                  r_v1, r_v2;
    logic [IDX_W-1:0]      r_i1, r_i2;
    logic [COUNT_BITS-1:0] r_c2;
    logic [P_W-1:0]        r_wt2, wt;
    logic [COUNT_BITS:0]   mult_a;
    logic [P_W-1:0]        mult_p;

    // accumulators
    logic [M_W-1:0]        r_u, r_factor;
    logic                  r_plain;
    logic [COUNT_BITS-1:0] r_w, r_sym_cnt, r_total_seen;
    logic [X_W-1:0]        r_total, r_cum, r_low, r_high, cum_next, val_x, tot;
    logic                  r_found_v;
    logic [IDX_W-1:0]      r_found;
    logic                  r_ovf;

    // output register
    logic                          r_out_valid;
    logic [asfm_pkg::RANGE_W-1:0]  r_o_low, r_o_high, r_o_total;
    logic [asfm_pkg::FOUND_W-1:0]  r_o_found;
    logic                          r_o_ovf;

    assign cfg_c = C_W'(r_cfg);
    assign max_c = C_W'(MAX_SYMBOLS);
    always_comb begin
        if (cfg_c == '0) begin
            m_c = C_W'(1);
        end else if (cfg_c > max_c) begin
            m_c = max_c;
        end else begin
            m_c = cfg_c;
        end
    end
    assign m = m_c[M_W-1:0];

    assign sym_c    = C_W'(r_sym);
    assign in_range = (sym_c < m_c);
    assign sym_idx  = sym_c[IDX_W-1:0];
    assign i2_c     = C_W'(r_i2);

    assign sat     = (r_total_seen == {COUNT_BITS{1'b1}});
    assign upd_wr  = i_cmd.update && (r_op == asfm_pkg::OP_ENCODE) && in_range && !sat;
    assign wr_en   = i_cmd.clr_wr || upd_wr;
    assign wr_addr = i_cmd.clr_wr ? i_idx : sym_idx;
    assign wr_data = i_cmd.clr_wr ? '0 : r_sym_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[i_idx];
    end

    // one shared multiplier: total while the total is formed, entry weight otherwise
    assign mult_a = i_cmd.calc_total ? ({1'b0, r_w} + 1'b1) : {1'b0, r_rdata};
    assign mult_p = mult_a * r_factor;

    always_comb begin
        if (r_plain) begin
            wt = P_W'(r_rdata);
        end else if (r_rdata != '0) begin
            wt = mult_p;
        end else begin
            wt = P_W'(1);
        end
    end

    assign tot      = r_plain ? X_W'(r_w) : X_W'(mult_p);
    assign cum_next = r_cum + X_W'(r_wt2);
    assign val_x    = X_W'(r_val);
    assign found_c  = r_found_v ? C_W'(r_found) : m_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= asfm_pkg::CFG_RESET;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_total_seen <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (upd_wr) begin
                r_total_seen <= r_total_seen + 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1  <= i_idx;
        r_i2  <= r_i1;
        r_c2  <= r_rdata;
        r_wt2 <= wt;

        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_sym     <= i_symbol;
            r_val     <= i_cumulative_value;
            r_u       <= '0;
            r_w       <= '0;
            r_found_v <= 1'b0;
            r_sym_cnt <= '0;
        end

        // distinct and total counts over the symbols in use
        if (r_v2 && !i_cmd.pass2 && (r_c2 != '0)) begin
            r_u <= r_u + 1'b1;
            r_w <= r_w + r_c2;
        end

        if (i_cmd.set_factor) begin
            r_factor <= m - r_u;
            r_plain  <= (r_u >= m);
        end

        // bounds default to the total when nothing matches
        if (i_cmd.calc_total) begin
            r_total <= tot;
            r_low   <= tot;
            r_high  <= tot;
            r_cum   <= '0;
        end

        if (r_v2 && i_cmd.pass2) begin
            r_cum <= cum_next;
            if (r_op == asfm_pkg::OP_ENCODE) begin
                if (i2_c == sym_c) begin
                    r_low     <= r_cum;
                    r_high    <= cum_next;
                    r_sym_cnt <= r_c2;
                end
            end else if (!r_found_v && (cum_next > val_x)) begin
                r_found_v <= 1'b1;
                r_found   <= r_i2;
                r_low     <= r_cum;
                r_high    <= cum_next;
            end
        end

        // hold the flag here so a waiting result keeps its own
        if (i_cmd.update) begin
            r_ovf <= (r_op == asfm_pkg::OP_ENCODE) && in_range && sat;
        end

        if (i_cmd.finish) begin
            r_o_low   <= r_low[asfm_pkg::RANGE_W-1:0];
            r_o_high  <= r_high[asfm_pkg::RANGE_W-1:0];
            r_o_total <= r_total[asfm_pkg::RANGE_W-1:0];
            r_o_found <= (r_op == asfm_pkg::OP_DECODE) ? found_c[asfm_pkg::FOUND_W-1:0] : '0;
            r_o_ovf   <= r_ovf;
        end
    end

    assign o_sts.last_idx  = ((C_W'(i_idx) + 1'b1) == m_c);
    assign o_sts.pipe_busy = r_v1 || r_v2;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_range_low    = r_o_low;
    assign o_range_high   = r_o_high;
    assign o_range_total  = r_o_total;
    assign o_found_symbol = r_o_found;
    assign o_overflow     = r_o_ovf;

endmodule

>>> src/adaptive_symbol_frequency_model.sv
// Adaptive symbol frequency model: after reset the count memory is swept to
// zero, one entry per cycle, and no item is taken until the sweep ends
// (configuration writes are taken at any time). Each item then makes two
// passes over the first M entries of the count memory, one entry per cycle
// through its single read port: the first forms the distinct and total
// counts, the second the weighted prefix sums. From acceptance until its
// result is loaded into the output register an item runs the first pass of
// M reads, a drain of the read pipeline, the escape factor, the total, the
// second pass of M reads, another drain, the count update and the output
// load. A result still waiting at the output holds the item in its last
// cycle. The next item is accepted at the edge after the result has been
// loaded, while that result may still wait to be taken, so a new item is
// never taken before the one before it is through.
module adaptive_symbol_frequency_model #(
    parameter int MAX_SYMBOLS = asfm_pkg::MAX_SYMBOLS_DEF,
    parameter int COUNT_BITS  = asfm_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [asfm_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_operation,
    input  logic [asfm_pkg::SYMBOL_W-1:0] i_symbol,
    input  logic [asfm_pkg::RANGE_W-1:0]  i_cumulative_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [asfm_pkg::RANGE_W-1:0]  o_range_low,
    output logic [asfm_pkg::RANGE_W-1:0]  o_range_high,
    output logic [asfm_pkg::RANGE_W-1:0]  o_range_total,
    output logic [asfm_pkg::FOUND_W-1:0]  o_found_symbol,
    output logic                          o_overflow
);

    `include "adaptive_symbol_frequency_model_defines.svh"

    localparam int IDX_W = asfm_pkg::idx_width(MAX_SYMBOLS);

    asfm_pkg::t_dp_cmd w_cmd;
    asfm_pkg::t_dp_sts w_sts;
    logic [IDX_W-1:0]  w_idx;

    asfm_ctrl #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    asfm_dp #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_idx              (w_idx),
        .o_sts              (w_sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_operation        (i_operation),
        .i_symbol           (i_symbol),
        .i_cumulative_value (i_cumulative_value),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_range_low        (o_range_low),
        .o_range_high       (o_range_high),
        .o_range_total      (o_range_total),
        .o_found_symbol     (o_found_symbol),
        .o_overflow         (o_overflow)
    );

    // one item in flight: an accepted item closes the input next cycle
    `ASFM_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // a result is never loaded over one that is still waiting
    `ASFM_ASSERT_IMP(a_finish_free, i_clk, i_rst_n, w_cmd.finish, w_sts.out_free)
    // the clearing sweep runs with the input closed and no reads in flight
    `ASFM_ASSERT_IMP(a_clear_closed, i_clk, i_rst_n, w_cmd.clr_wr, o_in_stall && !w_cmd.issue)
    // a refused count only comes from an encode, which reports symbol zero
    `ASFM_ASSERT_IMP(a_ovf_encode, i_clk, i_rst_n, o_out_valid && o_overflow, o_found_symbol == '0)

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the adaptive symbol frequency model
module testbench;

    localparam int QUIET_LIMIT  = 6000;
    localparam int DRAIN_CYCLES = 600;

    typedef struct packed {
        logic                          op;
        logic [asfm_pkg::SYMBOL_W-1:0] sym;
        logic [asfm_pkg::RANGE_W-1:0]  value;
        logic                          drain;
    } t_coder_req;

    typedef struct packed {
        logic [asfm_pkg::RANGE_W-1:0] low;
        logic [asfm_pkg::RANGE_W-1:0] high;
        logic [asfm_pkg::RANGE_W-1:0] total;
        logic [asfm_pkg::FOUND_W-1:0] found;
        logic                         ovf;
    } t_range_stats;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [asfm_pkg::CFG_W-1:0]    i_cfg_wdata;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic                          i_operation;
    logic [asfm_pkg::SYMBOL_W-1:0] i_symbol;
    logic [asfm_pkg::RANGE_W-1:0]  i_cumulative_value;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [asfm_pkg::RANGE_W-1:0]  o_range_low;
    logic [asfm_pkg::RANGE_W-1:0]  o_range_high;
    logic [asfm_pkg::RANGE_W-1:0]  o_range_total;
    logic [asfm_pkg::FOUND_W-1:0]  o_found_symbol;
    logic                          o_overflow;

    // shadow of the count table and the alphabet register
    bit [asfm_pkg::COUNT_BITS_DEF-1:0] sym_tally [asfm_pkg::MAX_SYMBOLS_DEF];
    bit [asfm_pkg::COUNT_BITS_DEF-1:0] tally_seen;
    bit [asfm_pkg::CFG_W-1:0]          alphabet_cfg = asfm_pkg::CFG_RESET;

    t_coder_req   coder_reqs[$];
    t_range_stats stats_due[$];
    t_coder_req   cur_req;
    int           issued;
    int           delivered;
    int           failures = 0;
    int           send_gap_pct;
    int           recv_gap_pct;
    int           quiet = 0;

    adaptive_symbol_frequency_model DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_symbol           (i_symbol),
        .i_cumulative_value (i_cumulative_value),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_range_low        (o_range_low),
        .o_range_high       (o_range_high),
        .o_range_total      (o_range_total),
        .o_found_symbol     (o_found_symbol),
        .o_overflow         (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] sym_weight(input int s, input bit plain,
                                               input logic [63:0] factor);
        if (plain)
            return 64'(sym_tally[s]);
        return (sym_tally[s] != 0) ? 64'(sym_tally[s]) * factor : 64'd1;
    endfunction

    // Work out the result of one item, then count an encoded symbol
    function automatic t_range_stats predict_stats(input t_coder_req rq);
        int           m;
        int           used;
        logic [63:0]  seen_sum;
        logic [63:0]  factor;
        logic [63:0]  total;
        logic [63:0]  cum;
        logic [63:0]  wt;
        bit           plain;
        t_range_stats st;
        m = (alphabet_cfg == 0) ? 1 :
            (alphabet_cfg > asfm_pkg::MAX_SYMBOLS_DEF) ? asfm_pkg::MAX_SYMBOLS_DEF :
            int'(alphabet_cfg);
        used = 0;
        seen_sum = 64'd0;
        for (int s = 0; s < m; s++) begin
            if (sym_tally[s] != 0) begin
                used++;
                seen_sum += 64'(sym_tally[s]);
            end
        end
        plain = (used >= m);
        factor = plain ? 64'd0 : 64'(m - used);
        total = plain ? seen_sum : factor * (seen_sum + 64'd1);
        st = '0;
        st.total = total[asfm_pkg::RANGE_W-1:0];
        st.low = total[asfm_pkg::RANGE_W-1:0];
        st.high = total[asfm_pkg::RANGE_W-1:0];
        if (rq.op == asfm_pkg::OP_ENCODE) begin
            if (int'(rq.sym) < m) begin
                cum = 64'd0;
                for (int s = 0; s < int'(rq.sym); s++)
                    cum += sym_weight(s, plain, factor);
                st.low = cum[asfm_pkg::RANGE_W-1:0];
                wt = cum + sym_weight(int'(rq.sym), plain, factor);
                st.high = wt[asfm_pkg::RANGE_W-1:0];
                if (tally_seen == '1) begin
                    st.ovf = 1'b1;
                end else begin
                    sym_tally[rq.sym]++;
                    tally_seen++;
                end
            end
        end else begin
            st.found = asfm_pkg::FOUND_W'(m);
            cum = 64'd0;
            for (int s = 0; s < m; s++) begin
                wt = sym_weight(s, plain, factor);
                if (cum + wt > 64'(rq.value)) begin
                    st.found = asfm_pkg::FOUND_W'(s);
                    st.low = cum[asfm_pkg::RANGE_W-1:0];
                    wt = cum + wt;
                    st.high = wt[asfm_pkg::RANGE_W-1:0];
                    break;
                end
                cum += wt;
            end
        end
        return st;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [asfm_pkg::RANGE_W-1:0] want,
                                        input logic [asfm_pkg::RANGE_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // Driver: present queued items, predict each one as it is accepted
    always @(posedge i_clk) begin : driver
        t_coder_req nxt;
        logic       taken;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            issued <= 0;
        end else begin
            taken = i_in_valid && !o_in_stall;
            if (taken) begin
                stats_due.push_back(predict_stats(cur_req));
                issued <= issued + 1;
            end
            if (!i_in_valid || taken) begin
                // a drain item waits until every earlier result is back
                if (coder_reqs.size() != 0 && $urandom_range(0, 99) >= send_gap_pct
                        && (!coder_reqs[0].drain || (!taken && issued == delivered))) begin
                    nxt = coder_reqs.pop_front();
                    cur_req <= nxt;
                    i_in_valid <= 1'b1;
                    i_operation <= nxt.op;
                    i_symbol <= nxt.sym;
                    i_cumulative_value <= nxt.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result against the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_range_stats want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            delivered <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                delivered <= delivered + 1;
                if (stats_due.size() == 0) begin
                    $error("result with no pending expectation");
                    failures++;
                end else begin
                    want = stats_due.pop_front();
                    check_field("range_low", want.low, o_range_low);
                    check_field("range_high", want.high, o_range_high);
                    check_field("range_total", want.total, o_range_total);
                    check_field("found_symbol", asfm_pkg::RANGE_W'(want.found),
                                asfm_pkg::RANGE_W'(o_found_symbol));
                    check_field("overflow", asfm_pkg::RANGE_W'(want.ovf),
                                asfm_pkg::RANGE_W'(o_overflow));
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    task automatic push_req(input logic op, input logic [asfm_pkg::SYMBOL_W-1:0] sym,
                            input logic [asfm_pkg::RANGE_W-1:0] value, input logic drain);
        t_coder_req rq;
        rq.op = op;
        rq.sym = sym;
        rq.value = value;
        rq.drain = drain;
        coder_reqs.push_back(rq);
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        while (coder_reqs.size() != 0 || i_in_valid || issued != delivered)
            @(negedge i_clk);
    endtask

    task automatic write_alphabet(input logic [asfm_pkg::CFG_W-1:0] cfg);
        wait_quiet();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cfg;
        alphabet_cfg <= cfg;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_random(input logic [asfm_pkg::CFG_W-1:0] cfg, input int count);
        int                            span;
        int                            roll;
        int                            k;
        logic                          op;
        logic [asfm_pkg::SYMBOL_W-1:0] sym;
        logic [asfm_pkg::RANGE_W-1:0]  value;
        write_alphabet(cfg);
        span = (cfg == 0) ? 1 :
               (cfg > asfm_pkg::MAX_SYMBOLS_DEF) ? asfm_pkg::MAX_SYMBOLS_DEF : int'(cfg);
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(0, 99) < 60) ? asfm_pkg::OP_ENCODE : asfm_pkg::OP_DECODE;
            roll = $urandom_range(0, 99);
            // crowd a few low symbols so the counts grow uneven
            if (roll < 35)
                sym = asfm_pkg::SYMBOL_W'($urandom_range(0, (span - 1) / 4));
            else if (roll < 85)
                sym = asfm_pkg::SYMBOL_W'($urandom_range(0, span - 1));
            else
                sym = asfm_pkg::SYMBOL_W'($urandom_range(0, 255));
            k = $urandom_range(0, 20);
            if ($urandom_range(0, 9) == 0)
                value = asfm_pkg::RANGE_W'({$urandom(), $urandom()});
            else
                value = asfm_pkg::RANGE_W'($urandom_range(0, (1 << k) - 1));
            push_req(op, sym, value, $urandom_range(0, 39) == 0);
        end
    endtask

    initial begin : stimulus
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_operation = asfm_pkg::OP_ENCODE;
        i_symbol = '0;
        i_cumulative_value = '0;
        i_out_stall = 1'b0;
        send_gap_pct = 9;
        recv_gap_pct = 60;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table at full alphabet: every weight is 1
        push_req(asfm_pkg::OP_DECODE, 8'd0, 41'd0, 1'b0);
        push_req(asfm_pkg::OP_DECODE, 8'hFF, 41'd255, 1'b0);
        push_req(asfm_pkg::OP_DECODE, 8'd0, 41'd256, 1'b0);
        push_req(asfm_pkg::OP_DECODE, 8'd0, {asfm_pkg::RANGE_W{1'b1}}, 1'b0);
        push_req(asfm_pkg::OP_ENCODE, 8'd0, 41'd0, 1'b0);
        push_req(asfm_pkg::OP_ENCODE, 8'hFF, {asfm_pkg::RANGE_W{1'b1}}, 1'b0);
        push_req(asfm_pkg::OP_ENCODE, 8'hFF, 41'd0, 1'b0);
        push_req(asfm_pkg::OP_DECODE, 8'd0, 41'd300, 1'b1);
        push_req(asfm_pkg::OP_ENCODE, 8'd128, 41'd0, 1'b1);

        // shrink the alphabet: counts above it stay but are ignored
        write_alphabet(9'd4);
        push_req(asfm_pkg::OP_ENCODE, 8'hFF, 41'd0, 1'b0);
        push_req(asfm_pkg::OP_DECODE, 8'd0, 41'd0, 1'b0);
        push_req(asfm_pkg::OP_ENCODE, 8'd1, 41'd0, 1'b0);
        push_req(asfm_pkg::OP_ENCODE, 8'd2, 41'd0, 1'b0);
        push_req(asfm_pkg::OP_ENCODE, 8'd3, 41'd0, 1'b0);
        push_req(asfm_pkg::OP_DECODE, 8'd0, 41'd0, 1'b0);
        push_req(asfm_pkg::OP_DECODE, 8'd0, 41'd4, 1'b0);
        push_req(asfm_pkg::OP_DECODE, 8'd0, 41'd1000, 1'b0);
        push_req(asfm_pkg::OP_ENCODE, 8'd3, 41'd0, 1'b0);

        // zero acts as one symbol
        write_alphabet(9'd0);
        push_req(asfm_pkg::OP_ENCODE, 8'd0, 41'd0, 1'b0);
        push_req(asfm_pkg::OP_ENCODE, 8'd200, 41'd0, 1'b0);
        push_req(asfm_pkg::OP_DECODE, 8'd0, 41'd1, 1'b0);
        push_req(asfm_pkg::OP_DECODE, 8'd0, 41'd1000, 1'b0);

        // above the table size acts as the full table
        write_alphabet(9'h1FF);
        push_req(asfm_pkg::OP_ENCODE, 8'd77, {asfm_pkg::RANGE_W{1'b1}}, 1'b0);
        push_req(asfm_pkg::OP_DECODE, 8'hFF, 41'd300, 1'b0);
        push_req(asfm_pkg::OP_ENCODE, 8'hFF, 41'd0, 1'b0);

        run_random(9'd2, 40);
        run_random(9'd8, 50);
        run_random(9'd1, 20);
        run_random(9'd64, 40);
        run_random(9'd256, 15);

        send_gap_pct = 60;
        recv_gap_pct = 9;
        run_random(9'd3, 40);
        run_random(9'd16, 50);
        run_random(9'd0, 15);
        run_random(9'h1FF, 15);
        run_random(9'd5, 45);

        send_gap_pct = 0;
        recv_gap_pct = 0;
        run_random(9'd4, 40);
        run_random(9'd32, 50);
        run_random(9'd128, 20);
        run_random(9'd6, 40);
        run_random(9'd256, 15);

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (stats_due.size() != 0) begin
            $error("%0d expected results never arrived", stats_due.size());
            failures++;
        end
        if (failures == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
